FILE: rtl/bloom_filter_insert_check_unit_macros.svh
// Assertion macros for the block's top module.
`ifndef BLOOM_FILTER_INSERT_CHECK_UNIT_MACROS_SVH
`define BLOOM_FILTER_INSERT_CHECK_UNIT_MACROS_SVH

// Checked on every clock edge once reset has been released.
`define BFIC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BFIC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bfic_pkg.sv
// ----------------------------------------------------------------------------
// bfic_pkg
// Types, constants and seed values shared by the Bloom filter modules.
// ----------------------------------------------------------------------------
package bfic_pkg;

	localparam int TOTAL_HASHES = 11;
	localparam int HASH_STEPS   = 12;
	localparam int SEL_BITS     = 4;

	localparam int FILTER_ADDR_BITS_DEF = 16;
	localparam int WORD_BITS_DEF        = 32;
	localparam int NUM_HASHES_DEF       = 11;

	localparam logic [31:0] RS_SEED   = 32'd63689;
	localparam logic [31:0] RS_STEP   = 32'd378551;
	localparam logic [31:0] BKDR_MUL  = 32'd131;
	localparam logic [31:0] FNV_MUL   = 32'h811C_9DC5;
	localparam logic [31:0] HIGH_NIB  = 32'hF000_0000;

	// Step codes of the shared hash unit.
	localparam logic [SEL_BITS-1:0] SEL_RS    = 4'd0;
	localparam logic [SEL_BITS-1:0] SEL_JS    = 4'd1;
	localparam logic [SEL_BITS-1:0] SEL_PJW   = 4'd2;
	localparam logic [SEL_BITS-1:0] SEL_ELF   = 4'd3;
	localparam logic [SEL_BITS-1:0] SEL_BKDR  = 4'd4;
	localparam logic [SEL_BITS-1:0] SEL_SDBM  = 4'd5;
	localparam logic [SEL_BITS-1:0] SEL_DJB   = 4'd6;
	localparam logic [SEL_BITS-1:0] SEL_DEK   = 4'd7;
	localparam logic [SEL_BITS-1:0] SEL_SXOR  = 4'd8;
	localparam logic [SEL_BITS-1:0] SEL_FNV   = 4'd9;
	localparam logic [SEL_BITS-1:0] SEL_AP    = 4'd10;
	localparam logic [SEL_BITS-1:0] SEL_RSMUL = 4'd11;

	typedef struct packed {
		logic [SEL_BITS-1:0] sel;
		logic                odd;
	} hash_cmd_t;

	function automatic logic [31:0] hash_seed(input logic [SEL_BITS-1:0] k,
			input logic [15:0] len);
		logic [31:0] s;
		s = '0;
		case (k)
			SEL_JS:  s = 32'd1315423911;
			SEL_DJB: s = 32'd5381;
			SEL_DEK: s = {16'd0, len};
			SEL_AP:  s = 32'hAAAA_AAAA;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/bfic_ram.sv
// ----------------------------------------------------------------------------
// bfic_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/bfic_hash_alu.sv
// ----------------------------------------------------------------------------
// bfic_hash_alu
// Shared hash step: one of the eleven string hashes, or the RS multiplier
// update, around a single 32x32 multiplier.
// ----------------------------------------------------------------------------
module bfic_hash_alu import bfic_pkg::*; (
	input  hash_cmd_t   cmd,
	input  logic [31:0] h,
	input  logic [31:0] rs,
	input  logic [31:0] d,
	output logic [31:0] result
);

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [31:0] p;
	logic [31:0] t;
	logic [31:0] hi;

	always_comb begin
		mul_a = h;
		mul_b = rs;
		unique case (cmd.sel)
			SEL_BKDR:  mul_b = BKDR_MUL;
			SEL_FNV:   mul_b = FNV_MUL;
			SEL_AP: begin
				mul_a = d;
				mul_b = h >> 3;
			end
			SEL_RSMUL: begin
				mul_a = rs;
				mul_b = RS_STEP;
			end
			default: mul_b = rs;
		endcase
	end

	assign prod = mul_a * mul_b;
	assign p    = prod[31:0];
	assign t    = (h << 4) + d;
	assign hi   = t & HIGH_NIB;

	always_comb begin
		unique case (cmd.sel)
			SEL_RS:   result = p + d;
			SEL_JS:   result = h ^ ((h << 5) + d + (h >> 2));
			SEL_PJW:  result = (hi != '0) ? ((t ^ (hi >> 24)) & ~HIGH_NIB) : t;
			SEL_ELF:  result = ((hi != '0) ? (t ^ (hi >> 24)) : t) & ~hi;
			SEL_BKDR: result = p + d;
			SEL_SDBM: result = d + (h << 6) + (h << 16) - h;
			SEL_DJB:  result = (h << 5) + h + d;
			SEL_DEK:  result = ((h << 5) ^ (h >> 27)) ^ d;
			SEL_SXOR: result = (h << 7) ^ d;
			SEL_FNV:  result = p ^ d;
			SEL_AP: begin
				if (!cmd.odd) begin
					result = h ^ ((h << 7) ^ p);
				end else begin
					result = h ^ ~(((h << 11) + d) ^ (h >> 5));
				end
			end
			SEL_RSMUL: result = p;
			default:   result = '0;
		endcase
	end

endmodule

FILE: rtl/bloom_filter_insert_check_unit.sv
// ----------------------------------------------------------------------------
// bloom_filter_insert_check_unit
// Bloom filter fed one key byte per request; inserts or checks a key.
// ----------------------------------------------------------------------------
// Each accepted byte makes twelve passes of the shared hash unit (eleven
// hashes and the RS multiplier update), which holds the single multiplier.
// A last byte adds bitmap probes, one per hash in use, each a read and then
// a test or write on the one RAM port, and then hands the result to the
// output register. After reset the bitmap's 2^FILTER_ADDR_BITS / WORD_BITS
// words (2048 by default) are cleared one word per cycle before the first
// request is taken. WORD_BITS must be a power of two no larger than
// 2^(FILTER_ADDR_BITS-1).
module bloom_filter_insert_check_unit import bfic_pkg::*; #(
	parameter int FILTER_ADDR_BITS = FILTER_ADDR_BITS_DEF,
	parameter int WORD_BITS        = WORD_BITS_DEF,
	parameter int NUM_HASHES       = NUM_HASHES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  key_byte,
	input  logic [15:0] key_length,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        done_opcode,
	output logic        present
);

	`include "bloom_filter_insert_check_unit_macros.svh"

	localparam int BIT_IDX = $clog2(WORD_BITS);
	localparam int WA      = FILTER_ADDR_BITS - BIT_IDX;
	localparam int DEPTH   = 2 ** WA;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_PROBE_RD, ST_PROBE_CHK, ST_RESULT
	} state_t;

	state_t                  state_q;
	logic [SEL_BITS-1:0]     step_q;
	logic [WA-1:0]           clr_q;
	logic                    key_open_q;
	logic                    opcode_q;
	logic                    last_q;
	logic                    all_set_q;
	logic                    pos_q;
	logic                    out_valid_q;
	logic                    done_opcode_q;
	logic                    present_q;
	logic [31:0]             d_q;
	logic [31:0]             rs_q;
	logic [31:0]             h_q [TOTAL_HASHES];
	logic [WA-1:0]           word_q;
	logic [BIT_IDX-1:0]      bit_q;

	logic                    accept;
	logic [31:0]             h_cur;
	logic [31:0]             alu_res;
	hash_cmd_t               cmd;
	logic                    ram_we;
	logic [WA-1:0]           ram_waddr;
	logic [WORD_BITS-1:0]    ram_wdata;
	logic [WORD_BITS-1:0]    ram_rdata;
	logic [WORD_BITS-1:0]    mask;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign done_opcode = done_opcode_q;
	assign present   = present_q;

	assign h_cur = (step_q < SEL_BITS'(TOTAL_HASHES)) ? h_q[step_q] : '0;
	assign cmd   = '{sel: step_q, odd: pos_q};
	assign mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_q;

	bfic_hash_alu u_alu (
		.cmd    (cmd),
		.h      (h_cur),
		.rs     (rs_q),
		.d      (d_q),
		.result (alu_res)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = ram_rdata | mask;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_PROBE_CHK && !opcode_q) begin
			ram_we = 1'b1;
		end
	end

	bfic_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (h_cur[FILTER_ADDR_BITS-1:BIT_IDX]),
		.rdata (ram_rdata)
	);

	// Hash accumulators: seeded on the first byte of a key.
	always_ff @(posedge clk) begin
		if (accept) begin
			d_q <= {{24{key_byte[7]}}, key_byte};
			if (!key_open_q) begin
				for (int k = 0; k < TOTAL_HASHES; k++) begin
					h_q[k] <= hash_seed(SEL_BITS'(k), key_length);
				end
				rs_q <= RS_SEED;
			end
		end else if (state_q == ST_HASH) begin
			if (step_q == SEL_RSMUL) begin
				rs_q <= alu_res;
			end else if (step_q < SEL_BITS'(TOTAL_HASHES)) begin
				h_q[step_q] <= alu_res;
			end
		end
		if (state_q == ST_PROBE_RD) begin
			word_q <= h_cur[FILTER_ADDR_BITS-1:BIT_IDX];
			bit_q  <= h_cur[BIT_IDX-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			step_q        <= '0;
			clr_q         <= '0;
			key_open_q    <= 1'b0;
			opcode_q      <= 1'b0;
			last_q        <= 1'b0;
			all_set_q     <= 1'b1;
			pos_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			done_opcode_q <= 1'b0;
			present_q     <= 1'b0;
		end else begin
			// In the result state the output register is handled there alone.
			if (out_valid_q && !out_stall && state_q != ST_RESULT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						opcode_q   <= opcode;
						last_q     <= last_byte;
						key_open_q <= !last_byte;
						if (!key_open_q) begin
							pos_q <= 1'b0;
						end
						step_q  <= '0;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (step_q == SEL_RSMUL) begin
						pos_q  <= !pos_q;
						step_q <= '0;
						if (last_q) begin
							all_set_q <= 1'b1;
							state_q   <= ST_PROBE_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_PROBE_RD: begin
					state_q <= ST_PROBE_CHK;
				end
				ST_PROBE_CHK: begin
					if ((ram_rdata & mask) == '0) begin
						all_set_q <= 1'b0;
					end
					if (step_q == SEL_BITS'(NUM_HASHES - 1)) begin
						state_q <= ST_RESULT;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_PROBE_RD;
					end
				end
				ST_RESULT: begin
					// The previous result must have left the output register first.
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						done_opcode_q <= opcode_q;
						present_q     <= opcode_q && all_set_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BFIC_ASSERT(a_accept_starts_hash, accept |=> (state_q == ST_HASH && step_q == '0), "accepted request did not start hashing")
	`BFIC_ASSERT(a_result_from_probe, $rose(out_valid_q) |-> $past(state_q == ST_RESULT), "result raised outside result state")
	`BFIC_ASSERT(a_insert_not_present, out_valid |-> (!present || done_opcode), "insert reported present")
	`BFIC_ASSERT(a_probe_bound, (state_q == ST_PROBE_CHK) |-> (step_q < SEL_BITS'(NUM_HASHES)), "probe index beyond hash count")
	`BFIC_ASSERT_ALWAYS(a_reset_stall, !arst_n |-> in_stall, "request stall low during reset")

endmodule

FILE: verif/tb_bloom_filter_insert_check_unit.sv
// ----------------------------------------------------------------------------
// tb_bloom_filter_insert_check_unit
// Feeds keys byte by byte as insert and check requests, predicts each result
// with an independent model of the eleven hashes and the bitmap, and compares.
// ----------------------------------------------------------------------------
module tb_bloom_filter_insert_check_unit;
	import bfic_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_BITS = FILTER_ADDR_BITS_DEF;
	localparam int N_HASH    = NUM_HASHES_DEF;
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_CHECK  = 1'b1;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic op;
		logic hit;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic [7:0]  key_byte;
	logic [15:0] key_length;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic        done_opcode;
	logic        present;

	bloom_filter_insert_check_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .key_byte(key_byte), .key_length(key_length),
		.last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.done_opcode(done_opcode), .present(present)
	);

	// Predictor state.
	logic [31:0] acc [TOTAL_HASHES];
	logic [31:0] rs_mul;
	logic [15:0] pos;
	bit          in_key;
	bit          bitmap [2**ADDR_BITS];

	verdict_t    pending[$];
	int          n_err, n_bytes, n_keys, n_hits, idle_cycles;
	bit          timed_out;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic absorb_byte(input logic [7:0] b, input logic [15:0] len);
		logic [31:0] d, t;
		if (!in_key) begin
			acc = '{32'd0, 32'd1315423911, 32'd0, 32'd0, 32'd0, 32'd0, 32'd5381,
				{16'd0, len}, 32'd0, 32'd0, 32'hAAAA_AAAA};
			rs_mul = 32'd63689;
			pos = '0;
			in_key = 1'b1;
		end
		d = {{24{b[7]}}, b};
		acc[0] = acc[0] * rs_mul + d;
		rs_mul = rs_mul * 32'd378551;
		acc[1] ^= (acc[1] << 5) + d + (acc[1] >> 2);
		acc[2] = (acc[2] << 4) + d;
		t = acc[2] & 32'hF000_0000;
		if (t != 0)
			acc[2] = (acc[2] ^ (t >> 24)) & 32'h0FFF_FFFF;
		acc[3] = (acc[3] << 4) + d;
		t = acc[3] & 32'hF000_0000;
		if (t != 0)
			acc[3] ^= t >> 24;
		acc[3] &= ~t;
		acc[4] = acc[4] * 32'd131 + d;
		acc[5] = d + (acc[5] << 6) + (acc[5] << 16) - acc[5];
		acc[6] = (acc[6] << 5) + acc[6] + d;
		acc[7] = ((acc[7] << 5) ^ (acc[7] >> 27)) ^ d;
		acc[8] = (acc[8] << 7) ^ d;
		acc[9] = (acc[9] * 32'h811C_9DC5) ^ d;
		if (!pos[0])
			acc[10] ^= (acc[10] << 7) ^ (d * (acc[10] >> 3));
		else
			acc[10] ^= ~(((acc[10] << 11) + d) ^ (acc[10] >> 5));
		pos = pos + 16'd1;
	endtask

	task automatic predict_request(input logic op, input logic [7:0] b,
			input logic [15:0] len, input logic fin);
		bit all_set;
		verdict_t v;
		absorb_byte(b, len);
		if (fin) begin
			all_set = 1'b1;
			for (int k = 0; k < N_HASH; k++) begin
				if (op == OP_INSERT)
					bitmap[acc[k][ADDR_BITS-1:0]] = 1'b1;
				else if (!bitmap[acc[k][ADDR_BITS-1:0]])
					all_set = 1'b0;
			end
			in_key = 1'b0;
			v.op = op;
			v.hit = (op == OP_CHECK) && all_set;
			pending.push_back(v);
			n_keys++;
		end
	endtask

	// Sender: bursts with random gaps between them. Valid stays high within a
	// burst and drops only for a gap.
	int burst_left;
	task automatic send_request(input logic op, input logic [7:0] b,
			input logic [15:0] len, input logic fin);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		opcode     <= op;
		key_byte   <= b;
		key_length <= len;
		last_byte  <= fin;
		do @(posedge clk); while (in_stall);
		predict_request(op, b, len, fin);
		n_bytes++;
	endtask

	task automatic send_key(input logic op, input byte unsigned k[], input logic [15:0] len);
		foreach (k[i])
			send_request(op, k[i], len, i == k.size() - 1);
	endtask

	task automatic test_directed();
		byte unsigned k[];
		k = '{8'h00};
		send_key(OP_CHECK, k, 16'd1);
		send_key(OP_INSERT, k, 16'd1);
		send_key(OP_CHECK, k, 16'd1);
		k = '{8'hFF, 8'h80, 8'h7F, 8'h01};
		send_key(OP_CHECK, k, 16'd4);
		send_key(OP_INSERT, k, 16'hFFFF);
		send_key(OP_CHECK, k, 16'hFFFF);
		send_key(OP_CHECK, k, 16'd4);
		// Only the first byte's length counts; only the last byte's opcode counts.
		send_request(OP_INSERT, 8'hA5, 16'd7, 1'b0);
		send_request(OP_CHECK, 8'h5A, 16'd1, 1'b0);
		send_request(OP_INSERT, 8'hC3, 16'd9, 1'b1);
		send_request(OP_CHECK, 8'hA5, 16'd7, 1'b0);
		send_request(OP_INSERT, 8'h5A, 16'd2, 1'b0);
		send_request(OP_CHECK, 8'hC3, 16'd3, 1'b1);
	endtask

	task automatic test_random(input int n_items);
		byte unsigned k[];
		byte unsigned keys[$][];
		int sent, len, pick;
		logic op;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 9);
			if (pick < 4 && keys.size() > 0) begin
				// Revisit a stored key so that checks can hit.
				k = keys[$urandom_range(0, keys.size() - 1)];
			end else begin
				len = (pick == 9) ? $urandom_range(20, 60) : $urandom_range(1, 6);
				k = new[len];
				foreach (k[i])
					k[i] = 8'($urandom_range(0, 255));
			end
			op = ($urandom_range(0, 1) != 0);
			if (op == OP_INSERT && keys.size() < 64)
				keys.push_back(k);
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(1, 65535);
			else
				len = k.size();
			send_key(op, k, len[15:0]);
			sent += k.size();
		end
	endtask

	// Receiver stall pattern: modes switch between none, sparse and heavy.
	int stall_mode;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Result checker and watchdog.
	verdict_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				if (pending.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("unexpected result: op=%0d present=%0d",
							done_opcode, present);
				end else begin
					want = pending.pop_front();
					if (done_opcode !== want.op || present !== want.hit) begin
						n_err++;
						if (n_err <= 10)
							$display("mismatch: expected op=%0d present=%0d, got op=%0d present=%0d",
								want.op, want.hit, done_opcode, present);
					end
					if (want.hit)
						n_hits++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("timeout: %0d results outstanding", pending.size());
			$display("tb_bloom_filter_insert_check_unit: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = 1'b0;
		key_byte = '0;
		key_length = '0;
		last_byte = 1'b0;
		n_err = 0;
		n_bytes = 0;
		n_keys = 0;
		n_hits = 0;
		idle_cycles = 0;
		burst_left = 0;
		in_key = 1'b0;
		timed_out = 1'b0;
		foreach (bitmap[i])
			bitmap[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(1500);
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d bytes in %0d keys; %0d checks found their key present.",
			n_bytes, n_keys, n_hits);
		if (n_err == 0)
			$display("tb_bloom_filter_insert_check_unit: PASS");
		else
			$display("tb_bloom_filter_insert_check_unit: FAIL");
		$finish;
	end

endmodule
